// File: src/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg - shared types and constants of the PID step block
// Operand widths of the shared multiplier and divider, their request
// structs, configuration register indexes and item op codes.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Shared multiplier: 64-bit magnitude times 32-bit factor
  localparam int MUL_A_W  = 64;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int MUL_HALF = MUL_A_W / 2;

  // Shared divider: 52-bit dividend, 20-bit divisor, two quotient bits a cycle
  localparam int DIV_N_W   = 52;
  localparam int DIV_D_W   = 20;
  localparam int DIV_STEPS = DIV_N_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd6;

  // Item op codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Fixed arithmetic constants
  localparam logic [DIV_D_W-1:0] US_PER_S    = 20'd1000000;
  localparam logic [16:0]        DECAY_ONE   = 17'd65536;
  localparam int                 DECAY_SHIFT = 16;
  localparam logic [31:0]        S32_MIN     = 32'h8000_0000;
  localparam logic [31:0]        S32_MAX     = 32'h7FFF_FFFF;
  localparam logic [63:0]        S64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0]        S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

endpackage

// File: src/pidc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mul - shared unsigned multiplier
// Multiplies a 64-bit magnitude by a 32-bit factor with one 32x32 multiplier,
// low half then high half, and pulses done when the product is ready.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  localparam logic [1:0] MP_IDLE = 2'd0;
  localparam logic [1:0] MP_LO   = 2'd1;
  localparam logic [1:0] MP_HI   = 2'd2;
  localparam logic [1:0] MP_ADD  = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic               done_q, done_d;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_A_W-1:0] pp_q;
  logic [MUL_P_W-1:0] acc_q;

  // Sequence the partial products
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MP_IDLE: if (req_i.start) phase_d = MP_LO;
      MP_LO:   phase_d = MP_HI;
      MP_HI:   phase_d = MP_ADD;
      MP_ADD:  phase_d = MP_IDLE;
      default: phase_d = MP_IDLE;
    endcase
    done_d = (phase_q == MP_ADD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Latch operands, form and accumulate partial products
  always_ff @(posedge clk_i) begin
    if (phase_q == MP_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (phase_q == MP_LO) begin
      pp_q <= MUL_A_W'(a_q[MUL_HALF-1:0]) * MUL_A_W'(b_q);
    end
    if (phase_q == MP_HI) begin
      acc_q <= MUL_P_W'(pp_q);
      pp_q  <= MUL_A_W'(a_q[MUL_A_W-1:MUL_HALF]) * MUL_A_W'(b_q);
    end
    if (phase_q == MP_ADD) begin
      acc_q <= acc_q + {pp_q, {MUL_HALF{1'b0}}};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: src/pidc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_div - shared unsigned divider
// Restoring division, two quotient bits per cycle, 52-bit dividend by a
// nonzero 20-bit divisor; pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   nq_q, nq_d;
  logic [DIV_D_W-1:0]   dsr_q;

  // Two compare-subtract steps per cycle
  always_comb begin
    logic [DIV_D_W:0]   r;
    logic [DIV_D_W-1:0] rem_v;
    logic [DIV_N_W-1:0] nq_v;
    rem_v = rem_q;
    nq_v  = nq_q;
    for (int j = 0; j < 2; j++) begin
      r    = {rem_v, nq_v[DIV_N_W-1]};
      nq_v = {nq_v[DIV_N_W-2:0], 1'b0};
      if (r >= {1'b0, dsr_q}) begin
        r       = r - {1'b0, dsr_q};
        nq_v[0] = 1'b1;
      end
      rem_v = r[DIV_D_W-1:0];
    end
    rem_d = rem_v;
    nq_d  = nq_v;
  end

  // Count the steps
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end else if (req_i.start) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Load operands or advance the shift registers
  always_ff @(posedge clk_i) begin
    if (cnt_q != '0) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
    end else if (req_i.start) begin
      rem_q <= '0;
      nq_q  <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

// File: src/pid_controller_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_step - PID update step in signed fixed point
// Sequencer with one shared multiplier and one shared divider computing
// error, decaying integral, derivative and the clamped drive output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one item: op_i, a
//   measurement and the elapsed interval. An update item gives one result
//   item on the output channel (out_valid_o / out_ready_i): the drive value
//   and a clamp flag. A clear item zeroes the integral and the previous
//   error and gives no result.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken;
//   write them only while the block is idle.
//   An update item goes, from acceptance until its result is loaded into
//   the output register, through six passes of the shared 32x32 multiplier,
//   two divisions and six further steps. in_ready_o is low meanwhile, so
//   the block takes no new item before that result is loaded.
//   A stalled receiver holds the result in the output register; the block
//   takes the next item meanwhile and waits before its own result only if
//   the previous one is still not taken.
//   Reset loads the register reset values and zeroes the integral and the
//   previous error.
// ----------------------------------------------------------------------------
module pid_controller_step import pidc_pkg::*; #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic signed [31:0]   measurement_i,
  input  logic        [19:0]   interval_us_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   drive_o,
  output logic                 clamped_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int SUM_W = INTEGRAL_WIDTH + 2;
  localparam logic [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INC_MUL   = 4'd1;
  localparam logic [3:0] ST_INC_DIV   = 4'd2;
  localparam logic [3:0] ST_INTEG     = 4'd3;
  localparam logic [3:0] ST_I_MUL     = 4'd4;
  localparam logic [3:0] ST_DECAY_MUL = 4'd5;
  localparam logic [3:0] ST_P_MUL     = 4'd6;
  localparam logic [3:0] ST_RATE_MUL  = 4'd7;
  localparam logic [3:0] ST_RATE_DIV  = 4'd8;
  localparam logic [3:0] ST_D_MUL     = 4'd9;
  localparam logic [3:0] ST_SUM_PI    = 4'd10;
  localparam logic [3:0] ST_SUM_D     = 4'd11;
  localparam logic [3:0] ST_CLAMP_HI  = 4'd12;
  localparam logic [3:0] ST_CLAMP_LO  = 4'd13;
  localparam logic [3:0] ST_OUT       = 4'd14;

  // Magnitude back to signed 64 bits, saturating
  function automatic logic [63:0] from_mag(input logic neg, input logic [MUL_P_W-1:0] m);
    logic ovf;
    logic [63:0] res;
    ovf = |m[MUL_P_W-1:63];
    if (neg) begin
      res = ovf ? S64_MIN : (64'd0 - m[63:0]);
    end else begin
      res = ovf ? S64_MAX : m[63:0];
    end
    return res;
  endfunction

  // Signed 64-bit add, saturating
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] res;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      res = s[64] ? S64_MIN : S64_MAX;
    end else begin
      res = s[63:0];
    end
    return res;
  endfunction

  // Configuration registers
  logic [31:0] target_q, out_min_q, out_max_q;
  logic [30:0] gain_p_q, gain_i_q, gain_d_q;
  logic [16:0] decay_q;

  // Sequencer state
  logic [3:0]    state_q, state_d;
  logic          issued_q, issued_d;
  logic [IW-1:0] integ_q, integ_d;
  logic [31:0]   prev_q, prev_d;
  logic          out_valid_q, out_valid_d;

  // Working payload
  logic [31:0]        e_q, e_d;
  logic [19:0]        dt_q, dt_d;
  logic [32:0]        inc_q, inc_d;
  logic [DIV_N_W-1:0] rate_mag_q, rate_mag_d;
  logic               rate_neg_q, rate_neg_d;
  logic [63:0]        pterm_q, pterm_d, iterm_q, iterm_d, dterm_q, dterm_d;
  logic [63:0]        acc_q, acc_d;
  logic               flag_q, flag_d;
  logic [31:0]        out_drive_q, out_drive_d;
  logic               out_clamped_q, out_clamped_d;

  // Shared units
  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quot;

  // Derived operands
  logic        in_fire;
  logic [32:0] err_wide;
  logic [31:0] err_sat;
  logic [31:0] e_mag;
  logic [32:0] diff, diff_negv;
  logic        diff_neg;
  logic [31:0] diff_mag;
  logic [63:0] integ_ext, integ_mag;
  logic [16:0] decay_eff;
  logic [SUM_W-1:0] integ_sum;
  logic [IW-1:0]    integ_clamped;
  logic             integ_in_range;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Error against the target, saturated to 32 bits
  assign err_wide = 33'($signed(target_q)) - 33'($signed(measurement_i));
  assign err_sat  = (err_wide[32] != err_wide[31]) ? (err_wide[32] ? S32_MIN : S32_MAX)
                                                   : err_wide[31:0];

  assign e_mag     = e_q[31] ? (32'd0 - e_q) : e_q;
  assign diff      = 33'($signed(e_q)) - 33'($signed(prev_q));
  assign diff_neg  = diff[32];
  assign diff_negv = 33'd0 - diff;
  assign diff_mag  = diff_neg ? diff_negv[31:0] : diff[31:0];
  assign integ_ext = 64'($signed(integ_q));
  assign integ_mag = integ_ext[63] ? (64'd0 - integ_ext) : integ_ext;
  assign decay_eff = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;

  // Integral plus increment, saturated to the integral width
  assign integ_sum      = SUM_W'($signed(integ_q)) + SUM_W'($signed(inc_q));
  assign integ_in_range = (&integ_sum[SUM_W-1:IW-1]) || !(|integ_sum[SUM_W-1:IW-1]);
  assign integ_clamped  = integ_in_range ? integ_sum[IW-1:0]
                                         : (integ_sum[SUM_W-1] ? IMIN : IMAX);

  // Select operands for the shared multiplier and divider
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      ST_INC_MUL: begin
        mul_req.a = MUL_A_W'(e_mag);
        mul_req.b = MUL_B_W'(dt_q);
      end
      ST_I_MUL: begin
        mul_req.a = integ_mag;
        mul_req.b = MUL_B_W'(gain_i_q);
      end
      ST_DECAY_MUL: begin
        mul_req.a = integ_mag;
        mul_req.b = MUL_B_W'(decay_eff);
      end
      ST_P_MUL: begin
        mul_req.a = MUL_A_W'(e_mag);
        mul_req.b = MUL_B_W'(gain_p_q);
      end
      ST_RATE_MUL: begin
        mul_req.a = MUL_A_W'(diff_mag);
        mul_req.b = MUL_B_W'(US_PER_S);
      end
      ST_D_MUL: begin
        mul_req.a = MUL_A_W'(rate_mag_q);
        mul_req.b = MUL_B_W'(gain_d_q);
      end
      default: mul_req = '0;
    endcase
    mul_req.start = !issued_q && (state_q == ST_INC_MUL || state_q == ST_I_MUL ||
                                  state_q == ST_DECAY_MUL || state_q == ST_P_MUL ||
                                  state_q == ST_RATE_MUL || state_q == ST_D_MUL);

    div_req.start    = !issued_q && (state_q == ST_INC_DIV || state_q == ST_RATE_DIV);
    div_req.dividend = mul_prod[DIV_N_W-1:0];
    div_req.divisor  = (state_q == ST_INC_DIV) ? US_PER_S : dt_q;
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    issued_d      = issued_q;
    integ_d       = integ_q;
    prev_d        = prev_q;
    out_valid_d   = out_valid_q;
    e_d           = e_q;
    dt_d          = dt_q;
    inc_d         = inc_q;
    rate_mag_d    = rate_mag_q;
    rate_neg_d    = rate_neg_q;
    pterm_d       = pterm_q;
    iterm_d       = iterm_q;
    dterm_d       = dterm_q;
    acc_d         = acc_q;
    flag_d        = flag_q;
    out_drive_d   = out_drive_q;
    out_clamped_d = out_clamped_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_i == OP_CLEAR) begin
            integ_d = '0;
            prev_d  = '0;
          end else begin
            e_d     = err_sat;
            dt_d    = (interval_us_i == '0) ? 20'd1 : interval_us_i;
            flag_d  = 1'b0;
            state_d = ST_INC_MUL;
          end
        end
      end
      ST_INC_MUL, ST_RATE_MUL: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          state_d  = (state_q == ST_INC_MUL) ? ST_INC_DIV : ST_RATE_DIV;
        end
      end
      ST_INC_DIV: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          inc_d    = e_q[31] ? (33'd0 - div_quot[32:0]) : div_quot[32:0];
          state_d  = ST_INTEG;
        end
      end
      ST_INTEG: begin
        integ_d = integ_clamped;
        state_d = ST_I_MUL;
      end
      ST_I_MUL: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          iterm_d  = from_mag(integ_q[IW-1], mul_prod >> FRAC_BITS);
          state_d  = ST_DECAY_MUL;
        end
      end
      ST_DECAY_MUL: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          integ_d  = IW'(from_mag(integ_q[IW-1], mul_prod >> DECAY_SHIFT));
          state_d  = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          pterm_d  = from_mag(e_q[31], mul_prod >> FRAC_BITS);
          state_d  = ST_RATE_MUL;
        end
      end
      ST_RATE_DIV: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (div_done) begin
          issued_d   = 1'b0;
          rate_mag_d = div_quot;
          rate_neg_d = diff_neg;
          state_d    = ST_D_MUL;
        end
      end
      ST_D_MUL: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          dterm_d  = from_mag(rate_neg_q, mul_prod >> FRAC_BITS);
          prev_d   = e_q;
          state_d  = ST_SUM_PI;
        end
      end
      ST_SUM_PI: begin
        acc_d   = sat_add(pterm_q, iterm_q);
        state_d = ST_SUM_D;
      end
      ST_SUM_D: begin
        acc_d   = sat_add(acc_q, dterm_q);
        state_d = ST_CLAMP_HI;
      end
      ST_CLAMP_HI: begin
        if ($signed(acc_q) > $signed(64'($signed(out_max_q)))) begin
          acc_d  = 64'($signed(out_max_q));
          flag_d = 1'b1;
        end
        state_d = ST_CLAMP_LO;
      end
      ST_CLAMP_LO: begin
        if ($signed(acc_q) < $signed(64'($signed(out_min_q)))) begin
          acc_d  = 64'($signed(out_min_q));
          flag_d = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_drive_d   = acc_q[31:0];
          out_clamped_d = flag_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, loop state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_min_q   <= S32_MIN;
      out_max_q   <= S32_MAX;
      decay_q     <= DECAY_ONE;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_TARGET:  target_q  <= cfg_data_i;
          CFG_GAIN_P:  gain_p_q  <= cfg_data_i[30:0];
          CFG_GAIN_I:  gain_i_q  <= cfg_data_i[30:0];
          CFG_GAIN_D:  gain_d_q  <= cfg_data_i[30:0];
          CFG_OUT_MIN: out_min_q <= cfg_data_i;
          CFG_OUT_MAX: out_max_q <= cfg_data_i;
          CFG_DECAY:   decay_q   <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    e_q           <= e_d;
    dt_q          <= dt_d;
    inc_q         <= inc_d;
    rate_mag_q    <= rate_mag_d;
    rate_neg_q    <= rate_neg_d;
    pterm_q       <= pterm_d;
    iterm_q       <= iterm_d;
    dterm_q       <= dterm_d;
    acc_q         <= acc_d;
    flag_q        <= flag_d;
    out_drive_q   <= out_drive_d;
    out_clamped_q <= out_clamped_d;
  end

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign drive_o     = $signed(out_drive_q);
  assign clamped_o   = out_clamped_q;

endmodule

// File: src/pidc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_checker - port-level checks of the PID step block
// Watches the top-level ports for sequencing and output hold behavior.
// ----------------------------------------------------------------------------
module pidc_checker import pidc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 op_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [31:0]   drive_o,
  input logic                 clamped_o
);

  // An update item keeps the block busy
  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == OP_UPDATE) |=> !in_ready_o)
    else $error("block ready right after taking an update item");

  // A clear item leaves the block ready again in the next cycle
  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == OP_CLEAR) |=> in_ready_o)
    else $error("block busy after a clear item");

  // A new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(drive_o) && $stable(clamped_o)))
    else $error("stalled result changed or dropped");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_o       (drive_o),
  .clamped_o     (clamped_o)
);
